// ===== rtl/core/sfrd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfrd_pkg
// Shared constants, codes and types of the sensor frame receiver and decoder.
// ----------------------------------------------------------------------------
package sfrd_pkg;

    // Frame geometry: two header bytes, type, length, payload, checksum
    localparam int MAX_FRAME = 20;
    localparam int PAY_BYTES = MAX_FRAME - 4;          // payload plus checksum
    localparam int POS_W     = (PAY_BYTES > 1) ? $clog2(PAY_BYTES) : 1;
    localparam int LEN_LIMIT = MAX_FRAME - 5;          // largest legal length byte
    localparam logic [7:0] LEN_LIMIT_B = 8'(LEN_LIMIT);
    localparam logic [7:0] HDR_BYTE    = 8'h5A;

    // Decode window: at least four bytes so the widest field always fits
    localparam int DEC_BYTES = (PAY_BYTES > 4) ? PAY_BYTES : 4;
    localparam int DEC_W     = DEC_BYTES * 8;

    // Field select bits of the type byte
    localparam int MB_TEMP  = 0;
    localparam int MB_HUM   = 1;
    localparam int MB_PRESS = 2;
    localparam int MB_IAQ   = 3;
    localparam int MB_GAS   = 4;
    localparam int MB_ALT   = 5;

    // Event queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_TYPE,
        PH_LEN,
        PH_BODY
    } t_phase;

    // One finished frame; payload byte 0 sits in the top bits
    typedef struct packed {
        t_status                    status;
        logic [7:0]                 mask;
        logic [PAY_BYTES*8-1:0]     payload;
    } t_frame_evt;

endpackage

// ===== rtl/core/sfrd_in_if.sv =====
// ----------------------------------------------------------------------------
// sfrd_in_if
// Receive byte channel: valid/ready handshake carrying one serial byte.
// ----------------------------------------------------------------------------
interface sfrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sfrd_out_if.sv =====
// ----------------------------------------------------------------------------
// sfrd_out_if
// Decoded frame channel: valid/ready handshake carrying one frame result.
// ----------------------------------------------------------------------------
interface sfrd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [7:0]         field_mask;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
    logic [23:0]        pressure;
    logic [11:0]        air_quality;
    logic [3:0]         air_quality_accuracy;
    logic [31:0]        gas_resistance;
    logic signed [15:0] altitude;

    modport source (output valid, output frame_status, output field_mask,
                    output temperature, output humidity, output pressure,
                    output air_quality, output air_quality_accuracy,
                    output gas_resistance, output altitude, input ready);
    modport sink   (input valid, input frame_status, input field_mask,
                    input temperature, input humidity, input pressure,
                    input air_quality, input air_quality_accuracy,
                    input gas_resistance, input altitude, output ready);
endinterface

// ===== rtl/core/sensor_frame_receive_decode.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_receive_decode
// Serial sensor frame receiver: header hunt, length check, additive checksum
// and field decode in type-mask order.
// ----------------------------------------------------------------------------
// Takes one received byte per clock. A frame is two 0x5A header bytes, a
// type byte (field mask), a length byte, that many payload bytes and an
// 8-bit checksum over all bytes before it. The checksum byte, or a length
// byte declaring more than a 20-byte frame, produces one result; the result
// passes through the event queue and then the registered result stage.
// Finished frames wait in a two-entry event queue between the byte front end
// and the decode stage, so input is refused only when that queue is full,
// which takes a stalled output with two further frame events behind it.
// No clearing pass runs after reset.
module sensor_frame_receive_decode import sfrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfrd_in_if.sink     i_rx,
    sfrd_out_if.source  o_res
);

    logic       push, q_ready, q_valid, pop;
    t_frame_evt push_evt, head_evt;

    // Byte front end
    sfrd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_evt     (push_evt)
    );

    // Frame event queue
    sfrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_evt   (head_evt),
        .i_pop   (pop)
    );

    // Decode and result stage
    sfrd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_evt   (head_evt),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/core/sfrd_front.sv =====
// ----------------------------------------------------------------------------
// sfrd_front
// Header hunt, length check, running checksum and payload capture. Pushes
// one event per finished or rejected frame.
// ----------------------------------------------------------------------------
module sfrd_front import sfrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfrd_in_if.sink     i_rx,
    input  logic        i_q_ready,
    output logic        o_push,
    output t_frame_evt  o_evt
);

    t_phase             r_phase, n_phase;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_mask, n_mask;
    logic [POS_W-1:0]   r_len, n_len;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_pay [PAY_BYTES];
    logic [7:0]         n_pay [PAY_BYTES];
    logic               accept;
    logic [7:0]         b;

    // Take a byte whenever the event queue has room
    assign i_rx.ready = i_q_ready;
    assign accept     = i_rx.valid && i_q_ready;
    assign b          = i_rx.rx_byte;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
        end
    end

    // Frame fields and payload bytes
    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        r_len  <= n_len;
        r_pos  <= n_pos;
        for (int k = 0; k < PAY_BYTES; k++) begin
            r_pay[k] <= n_pay[k];
        end
    end

    // Classify the received byte and advance the frame state
    always_comb begin
        n_phase      = r_phase;
        n_sum        = r_sum;
        n_mask       = r_mask;
        n_len        = r_len;
        n_pos        = r_pos;
        o_push       = 1'b0;
        o_evt.status = ST_GOOD;
        o_evt.mask   = r_mask;
        for (int k = 0; k < PAY_BYTES; k++) begin
            n_pay[k] = r_pay[k];
        end
        if (accept) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (b == HDR_BYTE) begin
                        n_sum   = b;
                        n_phase = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (b == HDR_BYTE) begin
                        n_sum   = r_sum + b;
                        n_phase = PH_TYPE;
                    end else begin
                        n_sum   = '0;
                        n_phase = PH_HUNT1;
                    end
                end
                PH_TYPE: begin
                    n_mask  = b;
                    n_sum   = r_sum + b;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (b > LEN_LIMIT_B) begin
                        // drop the frame at once and report it too long
                        o_push       = 1'b1;
                        o_evt.status = ST_TOO_LONG;
                        n_sum        = '0;
                        n_phase      = PH_HUNT1;
                    end else begin
                        n_len   = b[POS_W-1:0];
                        n_pos   = '0;
                        n_sum   = r_sum + b;
                        n_phase = PH_BODY;
                        // clear so bytes past the frame end read zero
                        for (int k = 0; k < PAY_BYTES; k++) begin
                            n_pay[k] = '0;
                        end
                    end
                end
                PH_BODY: begin
                    for (int k = 0; k < PAY_BYTES; k++) begin
                        if (r_pos == POS_W'(k)) begin
                            n_pay[k] = b;
                        end
                    end
                    if (r_pos == r_len) begin
                        // checksum byte closes the frame
                        o_push       = 1'b1;
                        o_evt.status = (r_sum == b) ? ST_GOOD : ST_BAD_SUM;
                        n_sum        = '0;
                        n_phase      = PH_HUNT1;
                    end else begin
                        n_sum = r_sum + b;
                        n_pos = r_pos + 1'b1;
                    end
                end
                default: begin
                    n_sum   = '0;
                    n_phase = PH_HUNT1;
                end
            endcase
        end
        for (int k = 0; k < PAY_BYTES; k++) begin
            o_evt.payload[(PAY_BYTES-1-k)*8 +: 8] = n_pay[k];
        end
    end

`ifndef SYNTHESIS
    a_push_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_phase == PH_LEN || r_phase == PH_BODY))
        else $error("frame event pushed outside length or body phase");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_pos <= r_len))
        else $error("payload position ran past the declared length");

    a_push_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_phase == PH_HUNT1 && r_sum == 8'h00))
        else $error("hunting did not restart after a frame event");
`endif

endmodule

// ===== rtl/core/sfrd_queue.sv =====
// ----------------------------------------------------------------------------
// sfrd_queue
// Short register queue of frame events between the front and the back.
// ----------------------------------------------------------------------------
module sfrd_queue import sfrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_evt  i_evt,
    output logic        o_ready,
    output logic        o_valid,
    output t_frame_evt  o_evt,
    input  logic        i_pop
);

    t_frame_evt         r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, n_wp;
    logic [QPTR_W-1:0]  r_rp, n_rp;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and fill count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Hold event entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("frame event pushed into a full queue");
`endif

endmodule

// ===== rtl/core/sfrd_back.sv =====
// ----------------------------------------------------------------------------
// sfrd_back
// Field decode in mask order and the registered result stage.
// ----------------------------------------------------------------------------
module sfrd_back import sfrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_frame_evt  i_evt,
    output logic        o_pop,
    sfrd_out_if.source  o_res
);

    logic               r_oval;
    t_status            r_status;
    logic [7:0]         r_mask;
    logic [15:0]        r_temp, n_temp;
    logic [15:0]        r_hum, n_hum;
    logic [23:0]        r_press, n_press;
    logic [11:0]        r_iaq, n_iaq;
    logic [3:0]         r_acc, n_acc;
    logic [31:0]        r_gas, n_gas;
    logic [15:0]        r_alt, n_alt;
    logic [DEC_W-1:0]   v;

    // Refill the result stage when it is empty or being taken
    assign o_pop = i_valid && (!r_oval || o_res.ready);

    // Walk the payload: each selected field takes the top bytes, then shifts
    always_comb begin
        v       = DEC_W'(i_evt.payload) << ((DEC_BYTES - PAY_BYTES) * 8);
        n_temp  = '0;
        n_hum   = '0;
        n_press = '0;
        n_iaq   = '0;
        n_acc   = '0;
        n_gas   = '0;
        n_alt   = '0;
        if (i_evt.mask[MB_TEMP]) begin
            n_temp = v[DEC_W-1 -: 16];
            v      = v << 16;
        end
        if (i_evt.mask[MB_HUM]) begin
            n_hum = v[DEC_W-1 -: 16];
            v     = v << 16;
        end
        if (i_evt.mask[MB_PRESS]) begin
            n_press = v[DEC_W-1 -: 24];
            v       = v << 24;
        end
        if (i_evt.mask[MB_IAQ]) begin
            n_acc = v[DEC_W-1 -: 4];
            n_iaq = v[DEC_W-5 -: 12];
            v     = v << 16;
        end
        if (i_evt.mask[MB_GAS]) begin
            n_gas = v[DEC_W-1 -: 32];
            v     = v << 32;
        end
        if (i_evt.mask[MB_ALT]) begin
            n_alt = v[DEC_W-1 -: 16];
        end
        // failed frames carry only status and mask
        if (i_evt.status != ST_GOOD) begin
            n_temp  = '0;
            n_hum   = '0;
            n_press = '0;
            n_iaq   = '0;
            n_acc   = '0;
            n_gas   = '0;
            n_alt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (o_pop) begin
            r_oval <= 1'b1;
        end else if (o_res.ready) begin
            r_oval <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_evt.status;
            r_mask   <= i_evt.mask;
            r_temp   <= n_temp;
            r_hum    <= n_hum;
            r_press  <= n_press;
            r_iaq    <= n_iaq;
            r_acc    <= n_acc;
            r_gas    <= n_gas;
            r_alt    <= n_alt;
        end
    end

    assign o_res.valid                = r_oval;
    assign o_res.frame_status         = r_status;
    assign o_res.field_mask           = r_mask;
    assign o_res.temperature          = r_temp;
    assign o_res.humidity             = r_hum;
    assign o_res.pressure             = r_press;
    assign o_res.air_quality          = r_iaq;
    assign o_res.air_quality_accuracy = r_acc;
    assign o_res.gas_resistance       = r_gas;
    assign o_res.altitude             = r_alt;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && r_status != ST_GOOD) |->
        (r_temp == '0 && r_hum == '0 && r_press == '0 && r_iaq == '0 &&
         r_acc == '0 && r_gas == '0 && r_alt == '0))
        else $error("failed frame result carries field data");
`endif

endmodule

// ===== test/sfrd_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfrd_frame_checker
// Watches the byte and result channels, predicts each decoded frame and
// compares every returned result field by field.
// ----------------------------------------------------------------------------
module sfrd_frame_checker import sfrd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sfrd_in_if    i_rx,
    sfrd_out_if   i_res,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct {
        t_status            status;
        logic [7:0]         mask;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic [23:0]        pressure;
        logic [11:0]        air_quality;
        logic [3:0]         air_quality_accuracy;
        logic [31:0]        gas_resistance;
        logic signed [15:0] altitude;
    } t_reading;

    // Shadow of the receiver state
    logic [7:0]  frame_bytes [MAX_FRAME];
    t_phase      rx_phase;
    int unsigned body_pos;
    logic [7:0]  frame_sum;

    t_reading    expected_readings [$];
    int          fail_count;

    // Frame byte at a position, zero at or past the end of the frame
    function automatic logic [7:0] byte_at(input int unsigned pos, input int unsigned flen);
        if (pos < flen && pos < MAX_FRAME) begin
            return frame_bytes[pos];
        end
        return 8'h00;
    endfunction

    function automatic logic [31:0] read_be(input int unsigned pos, input int unsigned n,
                                            input int unsigned flen);
        logic [31:0] v;
        v = '0;
        for (int unsigned k = 0; k < n; k++) begin
            v = {v[23:0], byte_at(pos + k, flen)};
        end
        return v;
    endfunction

    function automatic t_reading blank_reading(input t_status status, input logic [7:0] mask);
        t_reading r;
        r.status               = status;
        r.mask                 = mask;
        r.temperature          = '0;
        r.humidity             = '0;
        r.pressure             = '0;
        r.air_quality          = '0;
        r.air_quality_accuracy = '0;
        r.gas_resistance       = '0;
        r.altitude             = '0;
        return r;
    endfunction

    // Pull the selected fields out of the payload in mask order
    function automatic t_reading decode_frame(input int unsigned flen);
        t_reading    r;
        logic [7:0]  m;
        logic [7:0]  hi;
        int unsigned p;
        m = frame_bytes[2];
        r = blank_reading(ST_GOOD, m);
        p = 4;
        if (m[MB_TEMP]) begin
            r.temperature = 16'(read_be(p, 2, flen));
            p += 2;
        end
        if (m[MB_HUM]) begin
            r.humidity = 16'(read_be(p, 2, flen));
            p += 2;
        end
        if (m[MB_PRESS]) begin
            r.pressure = 24'(read_be(p, 3, flen));
            p += 3;
        end
        if (m[MB_IAQ]) begin
            hi = byte_at(p, flen);
            r.air_quality          = {hi[3:0], byte_at(p + 1, flen)};
            r.air_quality_accuracy = hi[7:4];
            p += 2;
        end
        if (m[MB_GAS]) begin
            r.gas_resistance = read_be(p, 4, flen);
            p += 4;
        end
        if (m[MB_ALT]) begin
            r.altitude = 16'(read_be(p, 2, flen));
        end
        return r;
    endfunction

    function automatic void restart_hunt();
        rx_phase  = PH_HUNT1;
        body_pos  = 0;
        frame_sum = '0;
    endfunction

    // Advance the shadow receiver by one byte; queue any finished frame
    function automatic void decode_rx_byte(input logic [7:0] b);
        int unsigned flen;
        case (rx_phase)
            PH_HUNT1: begin
                if (b == HDR_BYTE) begin
                    frame_bytes[0] = b;
                    frame_sum      = b;
                    rx_phase       = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (b == HDR_BYTE) begin
                    frame_bytes[1] = b;
                    frame_sum      = frame_sum + b;
                    rx_phase       = PH_TYPE;
                end else begin
                    restart_hunt();
                end
            end
            PH_TYPE: begin
                frame_bytes[2] = b;
                frame_sum      = frame_sum + b;
                rx_phase       = PH_LEN;
            end
            PH_LEN: begin
                frame_bytes[3] = b;
                if (int'(b) + 5 > MAX_FRAME) begin
                    expected_readings.push_back(blank_reading(ST_TOO_LONG, frame_bytes[2]));
                    restart_hunt();
                end else begin
                    frame_sum = frame_sum + b;
                    body_pos  = 4;
                    rx_phase  = PH_BODY;
                end
            end
            default: begin
                flen = int'(frame_bytes[3]) + 5;
                frame_bytes[body_pos] = b;
                if (body_pos + 1 >= flen) begin
                    if (frame_sum == b) begin
                        expected_readings.push_back(decode_frame(flen));
                    end else begin
                        expected_readings.push_back(blank_reading(ST_BAD_SUM, frame_bytes[2]));
                    end
                    restart_hunt();
                end else begin
                    frame_sum = frame_sum + b;
                    body_pos++;
                end
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Track accepted bytes, then compare accepted results
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            restart_hunt();
            expected_readings.delete();
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                decode_rx_byte(i_rx.rx_byte);
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result with no frame pending: status 0x%0h mask 0x%0h",
                           i_res.frame_status, i_res.field_mask);
                    fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("frame_status", 32'(want.status), 32'(i_res.frame_status));
                    check_field("field_mask", 32'(want.mask), 32'(i_res.field_mask));
                    check_field("temperature", 32'(want.temperature),
                                32'(i_res.temperature));
                    check_field("humidity", 32'(want.humidity), 32'(i_res.humidity));
                    check_field("pressure", 32'(want.pressure), 32'(i_res.pressure));
                    check_field("air_quality", 32'(want.air_quality),
                                32'(i_res.air_quality));
                    check_field("air_quality_accuracy", 32'(want.air_quality_accuracy),
                                32'(i_res.air_quality_accuracy));
                    check_field("gas_resistance", want.gas_resistance,
                                i_res.gas_resistance);
                    check_field("altitude", 32'(want.altitude), 32'(i_res.altitude));
                end
            end
        end
        o_pending    = expected_readings.size();
        o_fail_count = fail_count;
    end

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        restart_hunt();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the sensor frame receiver and decoder.
// ----------------------------------------------------------------------------
// Sends a few hand-picked frames, then random frames, noise and broken
// headers under changing sender and receiver idle rates, including one long
// receiver hold-off that backs the block up. Checking is done by the frame
// checker beside the block; this module only drives and gives the verdict.
module tb_top;
    import sfrd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_EDGE} t_fill;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfrd_in_if  rx_if ();
    sfrd_out_if res_if ();

    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req = 1'b0;
    int   hold_left = 0;

    sensor_frame_receive_decode DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    sfrd_frame_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #4 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls plus one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one byte, idling first at the current rate; return at the
    // falling edge after the request is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] fill_byte(input t_fill fill, input int pos);
        case (fill)
            FILL_ONES:  return 8'hFF;
            FILL_ZEROS: return 8'h00;
            FILL_EDGE:  return (pos % 2 == 0) ? 8'h80 : 8'h00;
            default: begin
                // Favor the sign and range edges now and then
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(3))
                        0:       return 8'h00;
                        1:       return 8'hFF;
                        2:       return 8'h7F;
                        default: return 8'h80;
                    endcase
                end
                return 8'($urandom_range(255));
            end
        endcase
    endfunction

    // Header, type, length, payload and checksum; stop after the length
    // byte when it declares an oversized frame
    task automatic send_frame(input logic [7:0] mask, input logic [7:0] len,
                              input bit bad_sum, input t_fill fill);
        logic [7:0] sum;
        logic [7:0] b;
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(mask);
        send_byte(len);
        if (int'(len) <= LEN_LIMIT) begin
            sum = HDR_BYTE + HDR_BYTE + mask + len;
            for (int i = 0; i < int'(len); i++) begin
                b   = fill_byte(fill, i);
                sum = sum + b;
                send_byte(b);
            end
            if (bad_sum) begin
                sum = sum ^ 8'($urandom_range(1, 255));
            end
            send_byte(sum);
        end
    endtask

    // Mostly well-formed frames, some oversized, noise and broken headers
    task automatic send_random_frame();
        int         pick;
        int         n;
        logic [7:0] b;
        logic [7:0] mask;
        logic [7:0] len;
        t_fill      fill;
        pick = $urandom_range(99);
        if (pick < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(3) == 0) begin
                    send_byte(HDR_BYTE);
                end else begin
                    send_byte(8'($urandom_range(255)));
                end
            end
        end else if (pick < 13) begin
            send_byte(HDR_BYTE);
            b = 8'($urandom_range(255));
            if (b == HDR_BYTE) begin
                b = ~b;
            end
            send_byte(b);
        end else if (pick < 21) begin
            send_frame(8'($urandom_range(255)), 8'($urandom_range(LEN_LIMIT + 1, 255)),
                       1'b0, FILL_RANDOM);
        end else begin
            if ($urandom_range(9) < 4) begin
                mask = 8'h3F | 8'($urandom_range(3) << 6);
            end else begin
                mask = 8'($urandom_range(255));
            end
            if ($urandom_range(99) < 35) begin
                len = 8'(LEN_LIMIT);
            end else begin
                len = 8'($urandom_range(0, LEN_LIMIT));
            end
            case ($urandom_range(9))
                0:       fill = FILL_ONES;
                1:       fill = FILL_ZEROS;
                2:       fill = FILL_EDGE;
                default: fill = FILL_RANDOM;
            endcase
            send_frame(mask, len, ($urandom_range(9) == 0), fill);
        end
    endtask

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: broken second header byte, length-zero frame whose field
        // reads the checksum, oversized lengths, a bad checksum
        send_byte(HDR_BYTE);
        send_byte(8'h00);
        send_frame(8'h01, 8'd0, 1'b0, FILL_RANDOM);
        send_frame(8'hFF, 8'(LEN_LIMIT + 1), 1'b0, FILL_RANDOM);
        send_frame(8'h00, 8'hFF, 1'b0, FILL_RANDOM);
        send_frame(8'h3F, 8'd2, 1'b1, FILL_RANDOM);

        // Slow receiver
        send_idle_pct = 19;
        recv_idle_pct = 88;
        while (bytes_sent < 300) send_random_frame();

        // Slow sender
        send_idle_pct = 88;
        recv_idle_pct = 19;
        while (bytes_sent < 580) send_random_frame();

        // Full rate, starting with a long result hold-off that fills the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (10) send_frame(8'($urandom_range(255)), 8'd0, 1'b0, FILL_RANDOM);
        while (bytes_sent < 870) send_random_frame();
        rx_if.valid <= 1'b0;

        // Drain outstanding results, then allow for the output register
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
